>>> rtl/tgmns_pkg.sv
package tgmns_pkg;

  localparam int TGMNS_MAX_ORDER  = 7;
  localparam int TGMNS_COORD_BITS = 24;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_DIM   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY_ORDER = 1'd1;

  localparam logic [1:0] GRID_DIM_RESET   = 2'd2;
  localparam logic [1:0] GRID_DIM_3D      = 2'd3;
  localparam logic [2:0] POLY_ORDER_RESET = 3'd4;

  // neighbor slots and coordinate axes
  localparam int NBR  = 3;
  localparam int NB_I = 0;
  localparam int NB_J = 1;
  localparam int NB_K = 2;
  localparam int NAX  = 3;

  typedef struct packed {
    logic use_i;
    logic use_j;
    logic use_k;
    logic three;
    logic last;
  } tgmns_flags_t;

endpackage

>>> rtl/tgmns_if.sv
interface tgmns_in_if import tgmns_pkg::*; #(
  parameter int COORD_BITS = TGMNS_COORD_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
  modport sink (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface tgmns_out_if import tgmns_pkg::*; #(
  parameter int COORD_BITS = TGMNS_COORD_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS:0]   min_spacing;

  modport source (output valid, output min_spacing, input ready);
  modport sink (input valid, input min_spacing, output ready);
endinterface

interface tgmns_cfg_if import tgmns_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/tgmns_cell.sv
module tgmns_cell import tgmns_pkg::*; #(
  parameter int W = 3 * TGMNS_COORD_BITS
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] node_r;

  always_ff @(posedge clk) begin
    if (en) begin
      node_r <= d;
    end
  end

  assign q = node_r;

endmodule

>>> rtl/tgmns_dist.sv
module tgmns_dist import tgmns_pkg::*; #(
  parameter int COORD_BITS = TGMNS_COORD_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      restart,
  input  logic                      in_vld,
  input  tgmns_flags_t              in_flags,
  input  logic [3*COORD_BITS-1:0]   cur_node,
  input  logic [3*COORD_BITS-1:0]   nb_node [NBR],
  output logic                      done,
  output logic [2*COORD_BITS+3:0]   done_min,
  output logic                      last_busy
);

  localparam int C       = COORD_BITS;
  localparam int DIF_W   = C + 1;
  localparam int SQ_W    = 2 * C + 1;
  localparam int SUM_W   = 2 * C + 2;
  localparam int LEAST_W = 2 * C + 4;

  // stage a: differences
  logic                    va_r;
  tgmns_flags_t            fa_r;
  logic signed [DIF_W-1:0] dif_r   [NBR][NAX];
  logic signed [DIF_W-1:0] dif_nxt [NBR][NAX];
  // stage b: squares
  logic                    vb_r;
  tgmns_flags_t            fb_r;
  logic [SQ_W-1:0]         sq_r    [NBR][NAX];
  logic [SQ_W-1:0]         sq_nxt  [NBR][NAX];
  logic signed [2*DIF_W-1:0] prod  [NBR][NAX];
  // stage c: squared distances
  logic                    vc_r;
  tgmns_flags_t            fc_r;
  logic [SUM_W-1:0]        sum_r   [NBR];
  logic [SUM_W-1:0]        sum_nxt [NBR];
  // stage d: running minimum
  logic [LEAST_W-1:0]      least_r;
  logic [LEAST_W-1:0]      cand;
  logic                    done_r;
  logic [LEAST_W-1:0]      done_min_r;

  always_comb begin
    for (int n = 0; n < NBR; n++) begin
      for (int a = 0; a < NAX; a++) begin
        dif_nxt[n][a] = DIF_W'(signed'(cur_node[(NAX-1-a)*C +: C]))
                      - DIF_W'(signed'(nb_node[n][(NAX-1-a)*C +: C]));
        prod[n][a]    = dif_r[n][a] * dif_r[n][a];
        sq_nxt[n][a]  = SQ_W'(unsigned'(prod[n][a]));
      end
      sum_nxt[n] = SUM_W'(sq_r[n][0]) + SUM_W'(sq_r[n][1])
                 + (fb_r.three ? SUM_W'(sq_r[n][2]) : SUM_W'(0));
    end
  end

  always_comb begin
    cand = least_r;
    if (fc_r.use_i && (LEAST_W'(sum_r[NB_I]) < cand)) begin
      cand = LEAST_W'(sum_r[NB_I]);
    end
    if (fc_r.use_j && (LEAST_W'(sum_r[NB_J]) < cand)) begin
      cand = LEAST_W'(sum_r[NB_J]);
    end
    if (fc_r.use_k && (LEAST_W'(sum_r[NB_K]) < cand)) begin
      cand = LEAST_W'(sum_r[NB_K]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      vc_r    <= 1'b0;
      done_r  <= 1'b0;
      least_r <= '1;
    end else begin
      va_r   <= in_vld;
      vb_r   <= va_r;
      vc_r   <= vb_r;
      done_r <= vc_r && fc_r.last;
      if (restart) begin
        least_r <= '1;
      end else if (vc_r) begin
        least_r <= fc_r.last ? '1 : cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    fa_r  <= in_flags;
    fb_r  <= fa_r;
    fc_r  <= fb_r;
    dif_r <= dif_nxt;
    sq_r  <= sq_nxt;
    sum_r <= sum_nxt;
    if (vc_r && fc_r.last) begin
      done_min_r <= cand;
    end
  end

  assign done      = done_r;
  assign done_min  = done_min_r;
  assign last_busy = (va_r && fa_r.last) || (vb_r && fb_r.last)
                  || (vc_r && fc_r.last) || done_r;

endmodule

>>> rtl/tgmns_isqrt.sv
module tgmns_isqrt import tgmns_pkg::*; #(
  parameter int COORD_BITS = TGMNS_COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [2*COORD_BITS+3:0] value,
  output logic                    busy,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS:0]     out_root
);

  localparam int LEAST_W = 2 * COORD_BITS + 4;
  localparam int ROOT_W  = COORD_BITS + 2;
  localparam int OUT_W   = COORD_BITS + 1;
  localparam int REM_W   = ROOT_W + 2;
  localparam int CNT_W   = $clog2(ROOT_W + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_t;

  state_t             state_r;
  logic [LEAST_W-1:0] val_r;
  logic [REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [OUT_W-1:0]   out_root_r;

  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic [REM_W-1:0]   rem_step;
  logic [ROOT_W-1:0]  root_step;
  logic [OUT_W-1:0]   root_sat;

  // one result bit per cycle, two value bits brought down each step
  always_comb begin
    rem_sh = {rem_r, val_r[LEAST_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_step  = REM_W'(rem_sh - trial);
      root_step = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      rem_step  = REM_W'(rem_sh);
      root_step = {root_r[ROOT_W-2:0], 1'b0};
    end
    root_sat = root_step[ROOT_W-1] ? {OUT_W{1'b1}} : root_step[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            val_r   <= value;
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= CNT_W'(ROOT_W);
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          val_r  <= {val_r[LEAST_W-3:0], 2'b00};
          rem_r  <= rem_step;
          root_r <= root_step;
          cnt_r  <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            out_root_r <= root_sat;
            state_r    <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_HOLD);
  assign out_root  = out_root_r;

endmodule

>>> rtl/tensor_grid_min_node_spacing_core.sv
// Minimum node spacing of tensor-grid elements. Nodes enter one per cycle, i fastest, then j,
// then k; a chain of (MAX_ORDER+1)^2 node cells gives each node its neighbors one node, one row
// and one plane back, and a four-stage distance pipeline keeps the least squared distance of the
// element. On the element's last node the least value goes to a bit-serial square root;
// min_spacing is offered from the root unit's output register and saturates to all ones when no
// pair was compared (order zero). All other nodes are taken every cycle, also while a result
// waits; a last node is held off only while the previous element is still in the pipeline, in
// the root unit or waiting in the output register. A configuration write is always accepted and
// restarts the element; the node cells are kept.
module tensor_grid_min_node_spacing_core import tgmns_pkg::*; #(
  parameter int MAX_ORDER  = TGMNS_MAX_ORDER,
  parameter int COORD_BITS = TGMNS_COORD_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  tgmns_in_if.sink      in_ch,
  tgmns_out_if.source   out_ch,
  tgmns_cfg_if.sink     cfg_ch
);

  localparam int NODES   = MAX_ORDER + 1;
  localparam int DEPTH   = NODES * NODES;
  localparam int AX_W    = $clog2(NODES);
  localparam int NODE_W  = 3 * COORD_BITS;
  localparam int LEAST_W = 2 * COORD_BITS + 4;

  logic [1:0]        grid_dim_r, grid_dim_nxt;
  logic [2:0]        poly_order_r, poly_order_nxt;
  logic [AX_W-1:0]   axis_i_r, axis_i_nxt;
  logic [AX_W-1:0]   axis_j_r, axis_j_nxt;
  logic [AX_W-1:0]   axis_k_r, axis_k_nxt;
  logic [AX_W-1:0]   ord;
  logic              three;
  tgmns_flags_t      flags;
  logic              in_rdy;
  logic              in_acc;
  logic              cfg_acc;

  logic [NODE_W-1:0] in_node;
  logic [NODE_W-1:0] cell_q [DEPTH];
  logic [NODE_W-1:0] row_tap;
  logic [NODE_W-1:0] plane_tap;
  logic [NODE_W-1:0] nb_node [NBR];

  logic               done;
  logic [LEAST_W-1:0] done_min;
  logic               last_busy;
  logic               root_busy;

  assign ord   = (32'(poly_order_r) > 32'(MAX_ORDER)) ? AX_W'(MAX_ORDER) : AX_W'(poly_order_r);
  assign three = (grid_dim_r == GRID_DIM_3D);

  always_comb begin
    flags.use_i = (axis_i_r != '0);
    flags.use_j = (axis_j_r != '0);
    flags.use_k = three && (axis_k_r != '0);
    flags.three = three;
    flags.last  = (axis_i_r == ord) && (axis_j_r == ord) && (!three || (axis_k_r == ord));
  end

  assign in_rdy       = !(flags.last && (last_busy || root_busy));
  assign in_ch.ready  = in_rdy;
  assign in_acc       = in_ch.valid && in_rdy;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  // configuration registers
  always_comb begin
    grid_dim_nxt   = grid_dim_r;
    poly_order_nxt = poly_order_r;
    if (cfg_acc) begin
      case (cfg_ch.index)
        REG_GRID_DIM:   grid_dim_nxt   = cfg_ch.data[1:0];
        REG_POLY_ORDER: poly_order_nxt = cfg_ch.data[2:0];
        default: begin
        end
      endcase
    end
  end

  // grid position of the next item
  always_comb begin
    axis_i_nxt = axis_i_r;
    axis_j_nxt = axis_j_r;
    axis_k_nxt = axis_k_r;
    if (cfg_acc || (in_acc && flags.last)) begin
      axis_i_nxt = '0;
      axis_j_nxt = '0;
      axis_k_nxt = '0;
    end else if (in_acc) begin
      if (axis_i_r < ord) begin
        axis_i_nxt = axis_i_r + AX_W'(1);
      end else begin
        axis_i_nxt = '0;
        if (axis_j_r < ord) begin
          axis_j_nxt = axis_j_r + AX_W'(1);
        end else begin
          axis_j_nxt = '0;
          axis_k_nxt = axis_k_r + AX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_dim_r   <= GRID_DIM_RESET;
      poly_order_r <= POLY_ORDER_RESET;
      axis_i_r     <= '0;
      axis_j_r     <= '0;
      axis_k_r     <= '0;
    end else begin
      grid_dim_r   <= grid_dim_nxt;
      poly_order_r <= poly_order_nxt;
      axis_i_r     <= axis_i_nxt;
      axis_j_r     <= axis_j_nxt;
      axis_k_r     <= axis_k_nxt;
    end
  end

  assign in_node = {in_ch.coord_x, in_ch.coord_y, in_ch.coord_z};

  // node chain, advanced once per item
  for (genvar p = 0; p < DEPTH; p++) begin : g_cell
    if (p == 0) begin : g_head
      tgmns_cell #(.W(NODE_W)) u_cell (
        .clk (clk),
        .en  (in_acc),
        .d   (in_node),
        .q   (cell_q[p])
      );
    end else begin : g_body
      tgmns_cell #(.W(NODE_W)) u_cell (
        .clk (clk),
        .en  (in_acc),
        .d   (cell_q[p-1]),
        .q   (cell_q[p])
      );
    end
  end

  // row and plane taps for the current order
  always_comb begin
    row_tap   = cell_q[0];
    plane_tap = cell_q[0];
    for (int q = 0; q < NODES; q++) begin
      if (ord == AX_W'(q)) begin
        row_tap   = cell_q[q];
        plane_tap = cell_q[(q + 1) * (q + 1) - 1];
      end
    end
  end

  assign nb_node[NB_I] = cell_q[0];
  assign nb_node[NB_J] = row_tap;
  assign nb_node[NB_K] = plane_tap;

  tgmns_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_acc),
    .in_vld    (in_acc),
    .in_flags  (flags),
    .cur_node  (in_node),
    .nb_node   (nb_node),
    .done      (done),
    .done_min  (done_min),
    .last_busy (last_busy)
  );

  tgmns_isqrt #(.COORD_BITS(COORD_BITS)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (done),
    .value     (done_min),
    .busy      (root_busy),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_root  (out_ch.min_spacing)
  );

endmodule
